@@ hw/rtl/fxq_alu_pkg.sv @@
// ----------------------------------------------------------------------------
// fxq_alu_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Word and fraction sizes, opcodes, pipeline stage map and the stage record.
// ----------------------------------------------------------------------------
package fxq_alu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;

    // Dividend of the divider is |a| << FRAC_BITS; the rounded product uses
    // the same number of low bits.
    localparam int EXT_BITS = WORD_BITS + FRAC_BITS;

    localparam logic [EXT_BITS-1:0] MUL_HALF = EXT_BITS'(1) << (FRAC_BITS - 1);

    // Two restoring steps per divider stage.
    localparam int DIV_STAGES = (EXT_BITS + 1) / 2;

    // Stage map
    localparam int STG_IN     = 0;
    localparam int STG_PREP   = 1;
    localparam int STG_DIV0   = 2;
    localparam int STG_RND    = STG_DIV0 + DIV_STAGES;
    localparam int STG_OUT    = STG_RND + 1;
    localparam int NUM_STAGES = STG_OUT + 1;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    typedef struct packed {
        logic [WORD_BITS:0]  rem;
        logic [EXT_BITS-1:0] num;
        logic [EXT_BITS-1:0] quo;
    } div_state_t;

    typedef struct packed {
        op_t                  op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic                 sa;
        logic                 neg;
        logic [WORD_BITS-1:0] ma;
        logic [WORD_BITS-1:0] mb;
        logic [EXT_BITS-1:0]  prod;
        logic [WORD_BITS-1:0] res;
        logic                 cmp;
        logic                 dz;
        div_state_t           dv;
    } stage_t;

endpackage

@@ hw/rtl/fixed_point_q24_8_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: pipelined Q24.8 fixed-point ALU
// Add, sub, rounded mul and div, compares, min/max, inc/dec and int
// conversions on signed 32-bit words, one request per beat.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  req     | req_type, operand_a, operand_b            | req_valid / req_stall
//  rsp     | result_value, compare_true, divide_by_zero| rsp_valid / rsp_stall
//
//  One beat enters per cycle while req_stall is low; a beat sits in NUM_STAGES
//  (24) registers and passes through all of them to the output register, any opcode.
//  Depth is set by the divider: 40 quotient bits, two restoring steps
//  (one 33-bit subtract each) per stage, 20 stages.
//  Reset clears only the valid bits; the payload registers are not reset.
//  A stalled output beat freezes the pipe and raises req_stall the same cycle.
//
module fixed_point_q24_8_alu
    import fxq_alu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [3:0]                  req_type,
    input  logic signed [WORD_BITS-1:0] operand_a,
    input  logic signed [WORD_BITS-1:0] operand_b,

    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic signed [WORD_BITS-1:0] result_value,
    output logic                        compare_true,
    output logic                        divide_by_zero
);

    // One restoring division step: shift in the next dividend bit, subtract
    // the divisor when it fits.
    function automatic div_state_t div_step(div_state_t st, logic [WORD_BITS-1:0] dvs);
        logic [WORD_BITS:0] trial;
        logic [WORD_BITS:0] diff;
        div_state_t         nx;
        trial  = {st.rem[WORD_BITS-1:0], st.num[EXT_BITS-1]};
        diff   = trial - {1'b0, dvs};
        nx.num = {st.num[EXT_BITS-2:0], 1'b0};
        if (trial >= {1'b0, dvs})
        begin
            nx.rem = diff;
            nx.quo = {st.quo[EXT_BITS-2:0], 1'b1};
        end
        else
        begin
            nx.rem = trial;
            nx.quo = {st.quo[EXT_BITS-2:0], 1'b0};
        end
        return nx;
    endfunction

    stage_t pipe_reg  [NUM_STAGES];
    stage_t pipe_next [NUM_STAGES];
    logic   [NUM_STAGES-1:0] valid_reg;
    logic   advance;

    // Global hold: only a stalled beat in the output register stops flow.
    assign advance   = !(valid_reg[STG_OUT] && rsp_stall);
    assign req_stall = !advance;

    // Input register
    always_comb
    begin
        pipe_next[STG_IN]    = pipe_reg[STG_IN];
        pipe_next[STG_IN].op = op_t'(req_type);
        pipe_next[STG_IN].a  = operand_a;
        pipe_next[STG_IN].b  = operand_b;
    end

    // Prep: magnitudes, signs and all single-adder operations
    always_comb
    begin
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic                 lt_ab;
        logic                 lt_ba;
        stage_t               st;
        st    = pipe_reg[STG_IN];
        a     = st.a;
        b     = st.b;
        lt_ab = $signed(a) < $signed(b);
        lt_ba = $signed(b) < $signed(a);

        st.sa    = a[WORD_BITS-1];
        st.neg   = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        st.ma    = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        st.mb    = b[WORD_BITS-1] ? (~b + 1'b1) : b;
        st.dz    = (st.op == OP_DIV) && (b == '0);
        st.dv.rem = '0;
        st.dv.quo = '0;
        st.dv.num = {st.ma, {FRAC_BITS{1'b0}}};
        st.prod  = '0;
        st.res   = '0;
        st.cmp   = 1'b0;

        case (st.op)
            OP_ADD:     st.res = a + b;
            OP_SUB:     st.res = a - b;
            OP_GT:      st.cmp = lt_ba;
            OP_LT:      st.cmp = lt_ab;
            OP_GE:      st.cmp = !lt_ab;
            OP_LE:      st.cmp = !lt_ba;
            OP_EQ:      st.cmp = (a == b);
            OP_NE:      st.cmp = (a != b);
            OP_MIN:     st.res = lt_ab ? a : b;
            OP_MAX:     st.res = lt_ba ? a : b;
            OP_INC:     st.res = a + 1'b1;
            OP_DEC:     st.res = a - 1'b1;
            OP_FROMINT: st.res = a << FRAC_BITS;
            default:    st.res = '0;   // mul, div, toint finish later
        endcase
        pipe_next[STG_PREP] = st;
    end

    // Divider stages; the multiplier finishes in the first three, toint in the first.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        always_comb
        begin
            logic [2*WORD_BITS-1:0] full_prod;
            logic [EXT_BITS-1:0]    rsum;
            stage_t                 st;
            st        = pipe_reg[STG_DIV0 + j - 1];
            full_prod = st.ma * st.mb;
            rsum      = st.prod + MUL_HALF;

            st.dv = div_step(st.dv, st.mb);
            if (2 * j + 1 < EXT_BITS)
            begin
                st.dv = div_step(st.dv, st.mb);
            end

            if (j == 0)
            begin
                st.prod = full_prod[EXT_BITS-1:0];
                if (st.op == OP_TOINT)
                begin
                    st.res = st.sa ? (~(st.ma >> FRAC_BITS) + 1'b1) : (st.ma >> FRAC_BITS);
                end
            end
            if (j == 1 && st.op == OP_MUL)
            begin
                st.res = rsum[EXT_BITS-1:FRAC_BITS];
            end
            if (j == 2 && st.op == OP_MUL && st.neg)
            begin
                st.res = ~st.res + 1'b1;
            end
            pipe_next[STG_DIV0 + j] = st;
        end
    end

    // Quotient rounding: half away from zero when 2*rem >= divisor
    always_comb
    begin
        stage_t st;
        st = pipe_reg[STG_RND - 1];
        if ({st.dv.rem, 1'b0} >= {2'b00, st.mb})
        begin
            st.dv.quo = st.dv.quo + 1'b1;
        end
        pipe_next[STG_RND] = st;
    end

    // Output register: sign and divide-by-zero for div
    always_comb
    begin
        stage_t st;
        st = pipe_reg[STG_RND];
        if (st.op == OP_DIV)
        begin
            if (st.dz)
                st.res = '0;
            else if (st.neg)
                st.res = ~st.dv.quo[WORD_BITS-1:0] + 1'b1;
            else
                st.res = st.dv.quo[WORD_BITS-1:0];
        end
        pipe_next[STG_OUT] = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    assign rsp_valid      = valid_reg[STG_OUT];
    assign result_value   = $signed(pipe_reg[STG_OUT].res);
    assign compare_true   = pipe_reg[STG_OUT].cmp;
    assign divide_by_zero = pipe_reg[STG_OUT].dz;

endmodule
